// ===== rtl/core/blhp_pkg.sv =====
// Shared types and constants for the BER LDAP message header parser.
package blhp_pkg;

    // Longest request in bytes; longer requests are reported invalid.
    localparam int MAX_REQUEST_BYTES = 65535;
    localparam int CNT_W             = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int LEN_W             = 32;
    localparam int SEQ_END_W         = LEN_W + 1;
    localparam int ID_W              = 32;

    // BER tag and length-form codes.
    localparam logic [7:0] TAG_SEQUENCE    = 8'h30;
    localparam logic [7:0] TAG_INTEGER     = 8'h02;
    localparam logic [7:0] TAG_BIND_REQ    = 8'h60;
    localparam logic [7:0] TAG_SEARCH_REQ  = 8'h63;
    localparam logic [7:0] TAG_UNBIND_REQ  = 8'h42;
    localparam logic [6:0] MAX_LEN_OCTETS  = 7'd4;

    typedef enum logic [3:0] {
        PH_SEQ_TAG  = 4'd0,
        PH_SEQ_LEN  = 4'd1,
        PH_SEQ_MORE = 4'd2,
        PH_INT_TAG  = 4'd3,
        PH_INT_LEN  = 4'd4,
        PH_INT_MORE = 4'd5,
        PH_ID       = 4'd6,
        PH_OP_TAG   = 4'd7,
        PH_DONE     = 4'd8,
        PH_ERROR    = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        REPLY_NONE   = 2'd0,
        REPLY_BIND   = 2'd1,
        REPLY_SEARCH = 2'd2,
        REPLY_OTHER  = 2'd3
    } reply_class_t;

    // One result beat as it travels from the parser to the output stage.
    typedef struct packed {
        logic             header_ok;
        logic [ID_W-1:0]  message_number;
        logic [7:0]       operation_tag;
        reply_class_t     reply_class;
    } result_t;

endpackage

// ===== rtl/core/blhp_parse.sv =====
// Parser state registers and the per-byte next-state logic.
module blhp_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    output logic              res_load,
    output blhp_pkg::result_t res
);
    import blhp_pkg::*;

    phase_t                 phase_reg,    phase_next;
    logic [CNT_W-1:0]       cnt_reg,      cnt_next;
    logic                   too_long_reg, too_long_next;
    logic [LEN_W-1:0]       len_reg,      len_next;
    logic [2:0]             len_left_reg, len_left_next;
    logic [SEQ_END_W-1:0]   seq_end_reg,  seq_end_next;
    logic [LEN_W-1:0]       id_left_reg,  id_left_next;
    logic [ID_W-1:0]        id_reg,       id_next;
    logic [7:0]             tag_reg,      tag_next;

    logic                   len_done;
    logic [LEN_W-1:0]       len_val;
    logic                   ok;
    reply_class_t           cls;

    // Next state for one accepted byte.
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        too_long_next = too_long_reg;
        len_next      = len_reg;
        len_left_next = len_left_reg;
        seq_end_next  = seq_end_reg;
        id_left_next  = id_left_reg;
        id_next       = id_reg;
        tag_next      = tag_reg;
        len_done      = 1'b0;
        len_val       = {{(LEN_W-8){1'b0}}, data_byte};

        // The byte counter saturates; reaching the limit marks the request too long.
        if (cnt_reg >= CNT_W'(MAX_REQUEST_BYTES))
        begin
            too_long_next = 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        case (phase_reg)
            PH_SEQ_TAG:
            begin
                phase_next = (data_byte == TAG_SEQUENCE) ? PH_SEQ_LEN : PH_ERROR;
            end
            PH_INT_TAG:
            begin
                phase_next = (data_byte == TAG_INTEGER) ? PH_INT_LEN : PH_ERROR;
            end
            PH_SEQ_LEN, PH_INT_LEN:
            begin
                if (!data_byte[7])
                begin
                    len_next = len_val;
                    len_done = 1'b1;
                end
                else if (data_byte[6:0] == 7'd0 || data_byte[6:0] > MAX_LEN_OCTETS)
                begin
                    phase_next = PH_ERROR;
                end
                else
                begin
                    len_next      = '0;
                    len_left_next = data_byte[2:0];
                    phase_next    = (phase_reg == PH_SEQ_LEN) ? PH_SEQ_MORE : PH_INT_MORE;
                end
            end
            PH_SEQ_MORE, PH_INT_MORE:
            begin
                len_val       = {len_reg[LEN_W-9:0], data_byte};
                len_next      = len_val;
                len_left_next = len_left_reg - 3'd1;
                len_done      = (len_left_next == 3'd0);
            end
            PH_ID:
            begin
                id_next      = {id_reg[ID_W-9:0], data_byte};
                id_left_next = id_left_reg - 1'b1;
                if (id_left_next == '0)
                begin
                    phase_next = PH_OP_TAG;
                end
            end
            PH_OP_TAG:
            begin
                tag_next   = data_byte;
                phase_next = PH_DONE;
            end
            default:
            begin
            end
        endcase

        // A complete length closes either the sequence header or the id header.
        if (len_done)
        begin
            if (phase_reg == PH_SEQ_LEN || phase_reg == PH_SEQ_MORE)
            begin
                seq_end_next = SEQ_END_W'(cnt_next) + SEQ_END_W'(len_val);
                phase_next   = PH_INT_TAG;
            end
            else
            begin
                id_left_next = len_val;
                phase_next   = (len_val == '0) ? PH_OP_TAG : PH_ID;
            end
        end
    end

    // Verdict and reply class on the final byte.
    always_comb
    begin
        ok = (phase_next == PH_DONE) && !too_long_next &&
             (seq_end_next <= SEQ_END_W'(cnt_next));
        if (!ok)
        begin
            cls = REPLY_NONE;
        end
        else if (tag_next == TAG_BIND_REQ)
        begin
            cls = REPLY_BIND;
        end
        else if (tag_next == TAG_SEARCH_REQ)
        begin
            cls = REPLY_SEARCH;
        end
        else if (tag_next == TAG_UNBIND_REQ)
        begin
            cls = REPLY_NONE;
        end
        else
        begin
            cls = REPLY_OTHER;
        end
        res_load           = take && final_byte;
        res.header_ok      = ok;
        res.message_number = ok ? id_next : '0;
        res.operation_tag  = ok ? tag_next : 8'd0;
        res.reply_class    = cls;
    end

    // State registers; the final byte returns the parser to its reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEQ_TAG;
            cnt_reg      <= '0;
            too_long_reg <= 1'b0;
            len_reg      <= '0;
            len_left_reg <= '0;
            seq_end_reg  <= '0;
            id_left_reg  <= '0;
            id_reg       <= '0;
            tag_reg      <= '0;
        end
        else if (take)
        begin
            if (final_byte)
            begin
                phase_reg    <= PH_SEQ_TAG;
                cnt_reg      <= '0;
                too_long_reg <= 1'b0;
                len_reg      <= '0;
                len_left_reg <= '0;
                seq_end_reg  <= '0;
                id_left_reg  <= '0;
                id_reg       <= '0;
                tag_reg      <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                cnt_reg      <= cnt_next;
                too_long_reg <= too_long_next;
                len_reg      <= len_next;
                len_left_reg <= len_left_next;
                seq_end_reg  <= seq_end_next;
                id_left_reg  <= id_left_next;
                id_reg       <= id_next;
                tag_reg      <= tag_next;
            end
        end
    end

endmodule

// ===== rtl/core/blhp_out.sv =====
// Result register with valid/ready handshake toward the receiver.
module blhp_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  blhp_pkg::result_t res,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              can_take,
    output blhp_pkg::result_t res_q
);
    import blhp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // The register may be refilled when it is empty or being drained.
    assign can_take = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset; it is qualified by the valid bit.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_q     = res_reg;

endmodule

// ===== rtl/core/ber_ldap_header_parser.sv =====
// Top level of the BER LDAP message header parser.
//
// The input channel (in_valid/in_ready) carries one request byte per beat,
// with final_byte set on the last byte of a request. The output channel
// (out_valid/out_ready) carries one result beat per request: header_ok,
// message_number, operation_tag and reply_class. Fields other than
// header_ok read as zero when the header is invalid.
// Each byte updates the parser state in the cycle it is accepted; the
// result of a request is presented in the cycle after its final byte.
// Throughput is one byte per cycle while in_ready is high; in_ready stays
// high while the single result register is empty or being drained.
// When the receiver stalls with a result held, in_ready drops and no byte
// is taken until the result beat completes.
// Reset (rst_n, asynchronous, active low) empties the result register and
// returns the parser to expect a sequence tag; after each final byte the
// parser returns to that state by itself.
module ber_ldap_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        header_ok,
    output logic [31:0] message_number,
    output logic [7:0]  operation_tag,
    output logic [1:0]  reply_class
);
    import blhp_pkg::*;

    logic    take;
    logic    res_load;
    logic    can_take;
    result_t res;
    result_t res_q;

    assign in_ready = can_take;
    assign take     = in_valid && can_take;

    blhp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .res_load   (res_load),
        .res        (res)
    );

    blhp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_take  (can_take),
        .res_q     (res_q)
    );

    assign header_ok      = res_q.header_ok;
    assign message_number = res_q.message_number;
    assign operation_tag  = res_q.operation_tag;
    assign reply_class    = res_q.reply_class;

endmodule
